// ===== hdl/mixed_numeric_total_order_compare_defines.svh =====
// Assertion macros shared by the comparator RTL
`ifndef MIXED_NUMERIC_TOTAL_ORDER_COMPARE_DEFINES_SVH
`define MIXED_NUMERIC_TOTAL_ORDER_COMPARE_DEFINES_SVH
// Assert that a condition implies a consequence on the same edge
`define MNTO_ASSERT_SAME(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) \
      else $error("assertion failed");
// Assert that a condition implies a consequence on the next edge
`define MNTO_ASSERT_NEXT(label, clk, rst, cond, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== hdl/mnto_pkg.sv =====
// Types and constants for the mixed numeric total order comparator
`timescale 1ns / 1ps
package mnto_pkg;
   typedef enum logic [1:0] {
      KIND_NULL = 2'd0,
      KIND_INT  = 2'd1,
      KIND_F32  = 2'd2,
      KIND_F64  = 2'd3
   } kind_type;

   localparam logic [1:0] ORDER_LESS    = 2'b11;
   localparam logic [1:0] ORDER_EQUAL   = 2'b00;
   localparam logic [1:0] ORDER_GREATER = 2'b01;

   // Decoded double: sign, special flags, magnitude as exponent and mantissa
   typedef struct packed {
      logic        sign;
      logic        nan;
      logic        inf;
      logic        zero;
      logic [10:0] expo;
      logic [52:0] mant;
      logic [63:0] bits;
   } dbl_type;

   function automatic logic [1:0] ord_of(input logic lt, input logic eq);
      logic [1:0] r;
      begin
         if (eq) r = ORDER_EQUAL;
         else if (lt) r = ORDER_LESS;
         else r = ORDER_GREATER;
         return r;
      end
   endfunction

   function automatic logic [1:0] ord_neg(input logic [1:0] o);
      return 2'(-o);
   endfunction
endpackage

// ===== hdl/mnto_widen.sv =====
// Widen a tagged value to double bits and decode its fields
`timescale 1ns / 1ps
module mnto_widen
   import mnto_pkg::*;
(
   input  logic [1:0]  kind,
   input  logic [63:0] bits,
   output dbl_type     dbl
);
   logic [7:0]  e32;
   logic [22:0] f32;
   logic [4:0]  lz;
   logic [22:0] fn;
   logic [63:0] w;
   logic        found;

   assign e32 = bits[30:23];
   assign f32 = bits[22:0];

   // Find leading one of a subnormal single fraction
   always_comb begin
      lz = 5'd0;
      found = 1'b0;
      for (int i = 22; i >= 0; i--) begin
         if (!found && f32[i]) begin
            lz = 5'(22 - i);
            found = 1'b1;
         end
      end
      fn = f32 << (lz + 5'd1);
   end

   // Build double bits; a NaN keeps its payload at the top and gains the quiet bit
   always_comb begin
      if (kind != KIND_F32) begin
         w = bits;
      end else if (e32 == 8'hFF) begin
         w = {bits[31], 11'h7FF, (f32[22] | (f32 != 23'd0)), f32[21:0], 29'd0};
      end else if (e32 == 8'd0) begin
         if (f32 == 23'd0) w = {bits[31], 63'd0};
         else w = {bits[31], 11'(11'd896 - 11'(lz)), fn, 29'd0};
      end else begin
         w = {bits[31], 11'(11'd896 + 11'(e32)), f32, 29'd0};
      end
   end

   always_comb begin
      dbl.bits = w;
      dbl.sign = w[63];
      dbl.expo = w[62:52];
      dbl.nan  = (w[62:52] == 11'h7FF) && (w[51:0] != 52'd0);
      dbl.inf  = (w[62:52] == 11'h7FF) && (w[51:0] == 52'd0);
      dbl.zero = (w[62:0] == 63'd0);
      dbl.mant = {(w[62:52] != 11'd0), w[51:0]};
   end
endmodule

// ===== hdl/mixed_numeric_total_order_compare.sv =====
// Top level: pipelined total order comparator of tagged numeric keys
//
//  channel | direction | ports
//  req     | in        | req_valid req_ready req_left_kind req_left_bits req_right_kind ..
//  rsp     | out       | rsp_valid rsp_ready rsp_order
//
// Four register stages: widen/decode, route/truncate, compare, output.
// One beat enters per cycle while the output is not stalled.
// A stall at rsp freezes the whole pipe; req_ready is low whenever the
// output beat is held, even with bubbles in the earlier stages.
// Synchronous active-high reset clears the valid bits only.
`timescale 1ns / 1ps
`include "mixed_numeric_total_order_compare_defines.svh"
module mixed_numeric_total_order_compare
   import mnto_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_left_kind,
   input  logic [63:0] req_left_bits,
   input  logic [1:0]  req_right_kind,
   input  logic [63:0] req_right_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_order
);
   // Stage valids; advance when the last stage is free
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic adv;
   assign adv = !v4_ff || rsp_ready;
   assign req_ready = adv;

   // Stage 1: widen and decode
   dbl_type ld, rd;
   mnto_widen u_wl (.kind(req_left_kind),  .bits(req_left_bits),  .dbl(ld));
   mnto_widen u_wr (.kind(req_right_kind), .bits(req_right_bits), .dbl(rd));

   logic [1:0]  lk1_ff, rk1_ff;
   dbl_type     ld1_ff, rd1_ff;
   logic [63:0] lb1_ff, rb1_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         lk1_ff <= req_left_kind;
         rk1_ff <= req_right_kind;
         ld1_ff <= ld;
         rd1_ff <= rd;
         lb1_ff <= req_left_bits;
         rb1_ff <= req_right_bits;
      end
   end

   // Stage 2: route the int side and the double side; truncate the double
   logic        swap_in, ii_in, ff_in, f32_in;
   logic [63:0] ival_in;
   dbl_type     dv_in;
   logic [63:0] trunc_in;
   logic        big_in, small_in;
   logic [63:0] mag;
   logic [11:0] sh;

   always_comb begin
      swap_in = (lk1_ff != KIND_INT) && (rk1_ff == KIND_INT);
      ii_in   = (lk1_ff == KIND_INT) && (rk1_ff == KIND_INT);
      f32_in  = (lk1_ff == KIND_F32) && (rk1_ff == KIND_F32);
      ff_in   = (lk1_ff != KIND_INT) && (rk1_ff != KIND_INT);
      ival_in = swap_in ? rb1_ff : lb1_ff;
      dv_in   = swap_in ? ld1_ff : rd1_ff;
      // |d| >= 2^63 when unbiased exponent >= 63
      big_in   = !dv_in.nan && !dv_in.sign && (dv_in.expo >= 11'd1086);
      small_in = !dv_in.nan && dv_in.sign &&
                 ((dv_in.expo > 11'd1086) ||
                  ((dv_in.expo == 11'd1086) && (dv_in.mant[51:0] != 52'd0)));
      // truncate toward zero for exponents below 63
      mag = 64'd0;
      sh  = 12'd0;
      if (dv_in.expo >= 11'd1075) begin
         sh  = 12'(dv_in.expo) - 12'd1075;
         mag = 64'(dv_in.mant) << sh[5:0];
      end else if (dv_in.expo >= 11'd1023) begin
         sh  = 12'd1075 - 12'(dv_in.expo);
         mag = 64'(dv_in.mant) >> sh[5:0];
      end
      trunc_in = dv_in.sign ? 64'(-mag) : mag;
   end

   logic        swap2_ff, ii2_ff, ff2_ff, f322_ff, big2_ff, small2_ff;
   logic [1:0]  lk2_ff, rk2_ff;
   logic [63:0] ival2_ff, trunc2_ff, lb2_ff, rb2_ff;
   dbl_type     dv2_ff, l2_ff, r2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         swap2_ff  <= swap_in;
         ii2_ff    <= ii_in;
         ff2_ff    <= ff_in;
         f322_ff   <= f32_in;
         big2_ff   <= big_in;
         small2_ff <= small_in;
         lk2_ff    <= lk1_ff;
         rk2_ff    <= rk1_ff;
         ival2_ff  <= ival_in;
         trunc2_ff <= trunc_in;
         lb2_ff    <= lb1_ff;
         rb2_ff    <= rb1_ff;
         dv2_ff    <= dv_in;
         l2_ff     <= ld1_ff;
         r2_ff     <= rd1_ff;
      end
   end

   // Stage 3: compare
   logic [1:0]  ord3_in;
   logic [1:0]  oi;
   logic        exact;
   logic [63:0] am;
   logic        ineg;
   logic [63:0] dmag_int;
   logic [1:0]  om;
   logic [31:0] la32, ra32;
   logic        frac;

   always_comb begin
      ineg = ival2_ff[63];
      am   = ineg ? 64'(-ival2_ff) : ival2_ff;
      exact = (am <= 64'h0020_0000_0000_0000);
      // Double has a nonzero fraction below the binary point
      frac = !dv2_ff.zero &&
             ((dv2_ff.expo < 11'd1023) ||
              ((dv2_ff.expo < 11'd1075) &&
               ((dv2_ff.mant & ((53'd1 << (11'd1075 - dv2_ff.expo)) - 53'd1)) != 53'd0)));
      // Integer side is exactly a double when small; compare via truncation
      // plus fractional remainder: truncated value equal means frac decides.
      dmag_int = trunc2_ff;
      oi = ORDER_EQUAL;
      if (dv2_ff.nan) begin
         oi = ORDER_GREATER;
      end else if (exact) begin
         // int vs double: compare int with trunc, tie broken by fraction
         if ($signed(ival2_ff) != $signed(dmag_int) || dv2_ff.inf ||
             dv2_ff.expo >= 11'd1086)
            oi = (dv2_ff.inf || dv2_ff.expo >= 11'd1086) ?
                 (dv2_ff.sign ? ORDER_GREATER : ORDER_LESS) :
                 ord_of($signed(ival2_ff) < $signed(dmag_int), 1'b0);
         else if (frac)
            oi = dv2_ff.sign ? ORDER_GREATER : ORDER_LESS;
         else
            oi = ORDER_EQUAL;
      end else if (big2_ff) begin
         oi = ORDER_LESS;
      end else if (small2_ff) begin
         oi = ORDER_GREATER;
      end else begin
         oi = ord_of($signed(ival2_ff) < $signed(trunc2_ff), ival2_ff == trunc2_ff);
      end

      // float against float
      la32 = lb2_ff[31:0];
      ra32 = rb2_ff[31:0];
      if (l2_ff.nan && r2_ff.nan)
         om = f322_ff ? ord_of(la32 < ra32, la32 == ra32)
                      : ord_of(l2_ff.bits < r2_ff.bits, l2_ff.bits == r2_ff.bits);
      else if (l2_ff.nan) om = ORDER_LESS;
      else if (r2_ff.nan) om = ORDER_GREATER;
      else if (l2_ff.zero && r2_ff.zero) om = ORDER_EQUAL;
      else if (l2_ff.sign != r2_ff.sign) om = l2_ff.sign ? ORDER_LESS : ORDER_GREATER;
      else if (l2_ff.bits[62:0] == r2_ff.bits[62:0]) om = ORDER_EQUAL;
      else om = ((l2_ff.bits[62:0] < r2_ff.bits[62:0]) ^ l2_ff.sign) ?
                ORDER_LESS : ORDER_GREATER;

      if (lk2_ff == KIND_NULL) ord3_in = (rk2_ff == KIND_NULL) ? ORDER_EQUAL : ORDER_LESS;
      else if (rk2_ff == KIND_NULL) ord3_in = ORDER_GREATER;
      else if (ii2_ff)
         ord3_in = ord_of($signed(lb2_ff) < $signed(rb2_ff), lb2_ff == rb2_ff);
      else if (ff2_ff) ord3_in = om;
      else ord3_in = swap2_ff ? ord_neg(oi) : oi;
   end

   logic [1:0] ord3_ff, ord4_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         ord3_ff <= ord3_in;
         ord4_ff <= ord3_ff;
      end
   end

   // Valid bits travel with the data
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_order = ord4_ff;

   `MNTO_ASSERT_SAME(a_order_legal, clock, reset, rsp_valid, rsp_order != 2'b10)
   `MNTO_ASSERT_NEXT(a_hold_stall, clock, reset, rsp_valid && !rsp_ready,
                     rsp_valid && $stable(rsp_order))
   `MNTO_ASSERT_SAME(a_ready_free, clock, reset, !rsp_valid, req_ready)
endmodule

// ===== verif/tb_mixed_numeric_total_order_compare.sv =====
// Testbench for the mixed numeric total order comparator, with a scoreboard predictor
`timescale 1ns / 1ps
module tb_mixed_numeric_total_order_compare
   import mnto_pkg::*;
;

   // Ordering predictor and queue of expected orders
   class order_scoreboard;
      logic [1:0] pending_orders[$];
      int errors;

      function new();
         errors = 0;
      endfunction

      function bit is_nan64(logic [63:0] b);
         return b[62:52] == 11'h7FF && b[51:0] != 52'd0;
      endfunction

      function bit is_nan32(logic [31:0] b);
         return b[30:23] == 8'hFF && b[22:0] != 23'd0;
      endfunction

      // Widen a single to double bits; NaNs keep payload and gain the quiet bit
      function logic [63:0] widen_single(logic [31:0] b);
         logic s;
         logic [7:0] e;
         logic [22:0] f;
         logic [52:0] t;
         int p;
         s = b[31];
         e = b[30:23];
         f = b[22:0];
         if (e == 8'hFF) begin
            if (f == 23'd0) return {s, 11'h7FF, 52'd0};
            return {s, 11'h7FF, ({f, 29'd0} | 52'h8000000000000)};
         end
         if (e == 8'd0) begin
            if (f == 23'd0) return {s, 63'd0};
            p = 22;
            while (!f[p]) p--;
            t = {1'b0, f, 29'd0} << (23 - p);
            return {s, 11'(p + 874), t[51:0]};
         end
         return {s, 11'(e) + 11'd896, f, 29'd0};
      endfunction

      function logic [63:0] as_double(kind_type k, logic [63:0] b);
         return k == KIND_F32 ? widen_single(b[31:0]) : b;
      endfunction

      function int sign_s64(longint a, longint b);
         return a == b ? 0 : (a < b ? -1 : 1);
      endfunction

      function int sign_real(real a, real b);
         return a == b ? 0 : (a < b ? -1 : 1);
      endfunction

      function int cmp_dbl(logic [63:0] a, logic [63:0] b);
         if (is_nan64(a) && is_nan64(b)) return a == b ? 0 : (a < b ? -1 : 1);
         if (is_nan64(a)) return -1;
         if (is_nan64(b)) return 1;
         return sign_real($bitstoreal(a), $bitstoreal(b));
      endfunction

      // Truncate a double below 2^63 in magnitude toward zero
      function longint trunc_dbl(logic [63:0] d);
         logic [63:0] mag;
         int e;
         if (d[62:52] < 11'd1023) return 0;
         e = int'(d[62:52]) - 1023;
         mag = {11'd0, 1'b1, d[51:0]};
         if (e >= 52) mag = mag << (e - 52);
         else mag = mag >> (52 - e);
         return d[63] ? -longint'(mag) : longint'(mag);
      endfunction

      function int cmp_int_dbl(longint l, logic [63:0] rb);
         real r;
         longint lim;
         lim = 64'sd1 <<< 53;
         if (is_nan64(rb)) return 1;
         r = $bitstoreal(rb);
         if (l <= lim && l >= -lim) return sign_real(real'(l), r);
         if (r >= 9223372036854775808.0) return -1;
         if (r < -9223372036854775808.0) return 1;
         return sign_s64(l, trunc_dbl(rb));
      endfunction

      function logic [1:0] predict_order(kind_type lk, logic [63:0] lb,
                                         kind_type rk, logic [63:0] rb);
         int r;
         if (lk == KIND_NULL) r = rk == KIND_NULL ? 0 : -1;
         else if (rk == KIND_NULL) r = 1;
         else if (lk == KIND_INT && rk == KIND_INT) r = sign_s64(lb, rb);
         else if (lk == KIND_INT) r = cmp_int_dbl(lb, as_double(rk, rb));
         else if (rk == KIND_INT) r = -cmp_int_dbl(rb, as_double(lk, lb));
         else if (lk == KIND_F32 && rk == KIND_F32) begin
            if (is_nan32(lb[31:0]) && is_nan32(rb[31:0]))
               r = lb[31:0] == rb[31:0] ? 0 : (lb[31:0] < rb[31:0] ? -1 : 1);
            else r = cmp_dbl(widen_single(lb[31:0]), widen_single(rb[31:0]));
         end else r = cmp_dbl(as_double(lk, lb), as_double(rk, rb));
         return 2'(r);
      endfunction

      function void note_request(kind_type lk, logic [63:0] lb,
                                 kind_type rk, logic [63:0] rb);
         pending_orders.push_back(predict_order(lk, lb, rk, rb));
      endfunction

      function void check_order(logic [1:0] got);
         logic [1:0] want;
         if (pending_orders.size() == 0) begin
            $error("order: expected none actual %0d", $signed(got));
            errors++;
            return;
         end
         want = pending_orders.pop_front();
         if (got !== want) begin
            $error("order: expected %0d actual %0d", $signed(want), $signed(got));
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_left_kind;
   logic [63:0] req_left_bits;
   logic [1:0]  req_right_kind;
   logic [63:0] req_right_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [1:0]  rsp_order;

   order_scoreboard sb = new();
   bit quiet_phase = 0;
   bit long_hold_req = 0;
   int hold_left = 0;
   int idle_cycles = 0;
   int beats_sent = 0;

   mixed_numeric_total_order_compare i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_left_kind(req_left_kind), .req_left_bits(req_left_bits),
      .req_right_kind(req_right_kind), .req_right_bits(req_right_bits),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_order(rsp_order)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   // Offer one beat, hold it until accepted, then maybe idle for a burst
   task automatic send_pair(kind_type lk, logic [63:0] lb, kind_type rk, logic [63:0] rb);
      req_valid      <= 1'b1;
      req_left_kind  <= lk;
      req_left_bits  <= lb;
      req_right_kind <= rk;
      req_right_bits <= rb;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_request(lk, lb, rk, rb);
      beats_sent++;
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
   endtask

   // Pick raw bits for a kind: full random, specials, small or boundary values
   function automatic logic [63:0] pick_bits(kind_type k);
      logic [63:0] specials[20] = '{
         64'h0, 64'h8000000000000000, 64'h7FF0000000000000, 64'hFFF0000000000000,
         64'h7FF8000000000000, 64'h7FF0000000000001, 64'hFFFFFFFFFFFFFFFF,
         64'h7FEFFFFFFFFFFFFF, 64'h0000000000000001, 64'h4340000000000000,
         64'h43E0000000000000, 64'hC3E0000000000000, 64'h7FFFFFFFFFFFFFFF,
         64'h000000007F800000, 64'h00000000FF800000, 64'h000000007FC00000,
         64'h000000007F800001, 64'h00000000FFFFFFFF, 64'h0000000080000000,
         64'h000000007F7FFFFF};
      longint v;
      case ($urandom_range(0, 4))
         0: return {$urandom, $urandom};
         1: begin
            v = specials[$urandom_range(0, 19)];
            if (k == KIND_F32) v[63:32] = $urandom;
            return v;
         end
         2: v = longint'($urandom_range(0, 40)) - 20;
         3: begin
            v = (64'sd1 <<< 53) + $urandom_range(0, 6) - 3;
            if ($urandom_range(0, 1)) v = v <<< $urandom_range(1, 10);
            if ($urandom_range(0, 1)) v = -v;
         end
         default: return {$urandom, $urandom};
      endcase
      if (k == KIND_F64) return $realtobits(real'(v));
      if (k == KIND_F32) return {$urandom, v[31:0]};
      return v;
   endfunction

   // Drive reset, directed pairs, then random pairs
   initial begin
      kind_type lk, rk;
      logic [63:0] lb, rb;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_left_kind  <= KIND_NULL;
      req_left_bits  <= '0;
      req_right_kind <= KIND_NULL;
      req_right_bits <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_pair(KIND_NULL, 64'h0, KIND_NULL, 64'hFFFFFFFFFFFFFFFF);
      send_pair(KIND_NULL, 64'h0, KIND_INT, 64'h8000000000000000);
      send_pair(KIND_F64, 64'hFFF0000000000000, KIND_NULL, 64'h0);
      send_pair(KIND_INT, 64'h7FFFFFFFFFFFFFFF, KIND_INT, 64'h8000000000000000);
      send_pair(KIND_INT, 64'hFFFFFFFFFFFFFFFF, KIND_INT, 64'h0);
      send_pair(KIND_F64, 64'h0, KIND_F64, 64'h8000000000000000);
      send_pair(KIND_F32, 64'hFFFFFFFF00000000, KIND_F32, 64'h0000000080000000);
      send_pair(KIND_F64, 64'h7FF8000000000000, KIND_F64, 64'hFFF8000000000001);
      send_pair(KIND_F32, 64'h7FC00000, KIND_F32, 64'h7F800001);
      send_pair(KIND_F64, 64'h7FF0000000000001, KIND_F64, 64'hFFF0000000000000);
      send_pair(KIND_F32, 64'h7F800001, KIND_F64, 64'h7FF8000020000000);
      send_pair(KIND_F32, 64'h00000001, KIND_F64, 64'h36A0000000000000);
      send_pair(KIND_F32, 64'h7F800000, KIND_F64, 64'h7FF0000000000000);
      send_pair(KIND_INT, 64'h0020000000000000, KIND_F64, 64'h4340000000000000);
      send_pair(KIND_INT, 64'h0020000000000001, KIND_F64, 64'h4340000000000000);
      send_pair(KIND_INT, 64'hFFDFFFFFFFFFFFFF, KIND_F64, 64'hC340000000000000);
      send_pair(KIND_INT, 64'h7FFFFFFFFFFFFFFF, KIND_F64, 64'h43E0000000000000);
      send_pair(KIND_INT, 64'h8000000000000000, KIND_F64, 64'hC3E0000000000000);
      send_pair(KIND_INT, 64'h8000000000000001, KIND_F64, 64'hC3E0000000000001);
      send_pair(KIND_F64, 64'h7FF0000000000000, KIND_INT, 64'h7FFFFFFFFFFFFFFF);
      send_pair(KIND_F32, 64'h7FC00000, KIND_INT, 64'h8000000000000000);
      send_pair(KIND_INT, 64'h0, KIND_F32, 64'hFFFFFFFF80000000);
      send_pair(KIND_F64, 64'h43F0000000000000, KIND_INT, 64'h7FFFFFFFFFFFFFFF);
      send_pair(KIND_INT, 64'h0, KIND_F64, 64'h3E80000000000000);
      send_pair(KIND_INT, 64'h0, KIND_F64, 64'hBE80000000000000);

      for (int n = 0; n < 1450; n++) begin
         if (n == 300) long_hold_req = 1;
         if (n == 1300) quiet_phase = 1;
         lk = kind_type'($urandom_range(0, 3));
         rk = kind_type'($urandom_range(0, 3));
         lb = pick_bits(lk);
         rb = pick_bits(rk);
         // Make the right side an equal or near-equal counterpart of the left
         if ($urandom_range(0, 2) == 0) begin
            if (lk == KIND_INT && rk == KIND_F64) rb = $realtobits(real'(longint'(lb)));
            else if (lk == KIND_F32 && rk == KIND_F64) rb = sb.widen_single(lb[31:0]);
            else if (lk == KIND_F64 && rk == KIND_INT && !sb.is_nan64(lb) &&
                     lb[62:52] < 11'd1085) rb = sb.trunc_dbl(lb);
            else if (lk == rk) rb = lb;
            if ($urandom_range(0, 1)) rb[1:0] = 2'(rb[1:0] + $urandom_range(0, 2) - 1);
         end
         send_pair(lk, lb, rk, rb);
      end
      req_valid <= 1'b0;

      while (sb.pending_orders.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.errors == 0 && sb.pending_orders.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   // Accept results, idle in bursts, and hold off once for a long stretch
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) sb.check_order(rsp_order);
         if (reset) begin
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left--;
         end else if (long_hold_req) begin
            long_hold_req = 0;
            hold_left = 200;
            rsp_ready <= 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
            hold_left = $urandom_range(1, 16) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Stop the run when neither channel moves a beat for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= 2000) begin
            $display("FAILURE");
            $finish;
         end
      end
   end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/mnto_pkg.sv
hdl/mnto_widen.sv
hdl/mixed_numeric_total_order_compare.sv
verif/tb_mixed_numeric_total_order_compare.sv
